// ----- rtl/sdc_pkg.sv -----
`default_nettype none

package sdc_pkg;

  // Chain size and derived widths
  localparam int NUM_MASSES = 10;
  localparam int IDX_W      = (NUM_MASSES > 1) ? $clog2(NUM_MASSES) : 1;
  localparam int MIDX_W     = 6;

  // Data widths: Q8.24 words, 25-bit step, shared multiplier operands
  localparam int DW         = 32;
  localparam int FRAC_W     = 24;
  localparam int DT_W       = 25;
  localparam int OP_W       = 34;
  localparam int PROD_W     = 2 * OP_W;
  localparam int RND_W      = PROD_W - FRAC_W;
  localparam int ACC_W      = 46;
  localparam int KQ_W       = 29;

  // Reciprocal of ten: floor(n / 10) = (n * RECIP_10) >> RECIP_SHIFT for n < 2^34
  localparam logic [OP_W-1:0] RECIP_10    = 34'd6871947674;
  localparam int              RECIP_SHIFT = 36;
  localparam logic [DW-1:0]   KQ_BIAS     = 32'd5;

  // Register reset values
  localparam logic [DW-1:0]   STIFF_RST = 32'd16777216;
  localparam logic [DW-1:0]   DAMP_RST  = 32'd1677722;
  localparam logic [DT_W-1:0] DT_RST    = 25'd167772;
  localparam logic [DW-1:0]   TOTAL_RST = 32'd1000;

  // Register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFFNESS   = 2'd0,
    REG_DAMPING     = 2'd1,
    REG_TIME_STEP   = 2'd2,
    REG_TOTAL_STEPS = 2'd3
  } cfg_reg_t;

  // State of one mass
  typedef struct packed {
    logic signed [DW-1:0] pos;
    logic signed [DW-1:0] vel;
  } mass_t;

  typedef logic signed [DW-1:0] pos_table_t [NUM_MASSES];

  // Initial perturbation: 0.01 * sin(0.5 i) through the Chebyshev recurrence
  localparam longint SIN_HALF_Q30     = 64'sd514779252;
  localparam longint TWO_COS_HALF_Q30 = 64'sd1884594201;

  function automatic pos_table_t init_pos_table();
    pos_table_t t;
    longint prev;
    longint cur;
    longint nxt;
    longint prod;
    longint mag;
    t[0] = '0;
    prev = 0;
    cur  = SIN_HALF_Q30;
    for (int i = 1; i < NUM_MASSES; i++) begin
      mag  = (cur < 0) ? -cur : cur;
      mag  = (mag + 3200) / 6400;
      t[i] = DW'((cur < 0) ? -mag : mag);
      prod = TWO_COS_HALF_Q30 * cur;
      mag  = (prod < 0) ? -prod : prod;
      mag  = (mag + (64'sd1 <<< 29)) >>> 30;
      nxt  = ((prod < 0) ? -mag : mag) - prev;
      prev = cur;
      cur  = nxt;
    end
    return t;
  endfunction

  localparam pos_table_t INIT_POS = init_pos_table();

  // Shift a product right by the fraction width, rounding ties away from zero
  function automatic logic signed [RND_W-1:0] rnd_frac(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + (p[PROD_W-1] ? PROD_W'(24'h7FFFFF) : PROD_W'(24'h800000));
    return s[PROD_W-1:FRAC_W];
  endfunction

  // Clamp a wide sum to a signed 32-bit word
  function automatic logic signed [DW-1:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic signed [DW-1:0] r;
    if ((&v[ACC_W-1:DW-1]) || !(|v[ACC_W-1:DW-1])) begin
      r = v[DW-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/spring_damper_chain_step.sv -----
`default_nettype none

// Channel   Signals                                    Direction  Moves
// input     in_valid, in_ready, restart                in         one tick or restart
// output    out_valid, out_ready, mass_index ... last  out        one mass per transaction
// config    cfg_we, cfg_index, cfg_wdata               in         one register write
//
// A running step takes the item in S_IDLE, computes the coupling constant in
// S_KQ and S_KQW, then works each mass through the shared multiplier sequence
// S_M0 to S_M8 and hands it back in S_EMIT. A restart or a tick after the run
// has finished goes from S_IDLE straight to S_EMIT. Reset loads the table at once.
// A stalled output holds the sequencer in its hand-off state; a new item is
// taken once the last mass of the previous one sits in the output register.

module spring_damper_chain_step (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [sdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [sdc_pkg::DW-1:0]               cfg_wdata,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 restart,
  // output channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [sdc_pkg::MIDX_W-1:0]                mass_index,
  output logic signed [sdc_pkg::DW-1:0]             position,
  output logic signed [sdc_pkg::DW-1:0]             velocity,
  output logic signed [sdc_pkg::DW-1:0]             acceleration,
  output logic [sdc_pkg::DW-1:0]                    step_count,
  output logic                                      done_res,
  output logic                                      last
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_KQ   = 13'b0000000000010,
    S_KQW  = 13'b0000000000100,
    S_M0   = 13'b0000000001000,
    S_M1   = 13'b0000000010000,
    S_M2   = 13'b0000000100000,
    S_M3   = 13'b0000001000000,
    S_M4   = 13'b0000010000000,
    S_M5   = 13'b0000100000000,
    S_M6   = 13'b0001000000000,
    S_M7   = 13'b0010000000000,
    S_M8   = 13'b0100000000000,
    S_EMIT = 13'b1000000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [sdc_pkg::DW-1:0]   stiffness;
  logic [sdc_pkg::DW-1:0]   damping;
  logic [sdc_pkg::DT_W-1:0] time_step;
  logic [sdc_pkg::DW-1:0]   total_steps;

  // Sequencer state
  logic [sdc_pkg::IDX_W-1:0] idx;
  logic [sdc_pkg::DW-1:0]    steps;
  logic                      run;
  logic [sdc_pkg::KQ_W-1:0]  kq;
  logic signed [sdc_pkg::DW-1:0]    x_l;
  logic signed [sdc_pkg::ACC_W-1:0] force_sum;
  logic signed [sdc_pkg::DW-1:0]    acc;
  logic signed [sdc_pkg::DW-1:0]    v_new;
  logic signed [sdc_pkg::DW-1:0]    x_new;

  // Chain of cells
  sdc_pkg::mass_t chain    [sdc_pkg::NUM_MASSES];
  sdc_pkg::mass_t chain_in [sdc_pkg::NUM_MASSES];
  sdc_pkg::mass_t tail_in;

  logic signed [sdc_pkg::DW-1:0]     x;
  logic signed [sdc_pkg::DW-1:0]     v;
  logic signed [sdc_pkg::DW-1:0]     x_r;
  logic signed [sdc_pkg::DW:0]       diff_l;
  logic signed [sdc_pkg::DW:0]       diff_r;
  logic signed [sdc_pkg::OP_W-1:0]   mul_a;
  logic signed [sdc_pkg::OP_W-1:0]   mul_b;
  logic signed [sdc_pkg::PROD_W-1:0] prod;
  logic signed [sdc_pkg::RND_W-1:0]  r;
  logic signed [sdc_pkg::ACC_W-1:0]  force_fin;

  logic in_fire;
  logic emit_fire;
  logic cell_load;
  logic run_next;
  logic is_first;
  logic is_last;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign emit_fire = (state == S_EMIT) && (!out_valid || out_ready);
  assign cell_load = in_fire && restart;
  assign run_next  = !restart && (steps < total_steps);
  assign is_first  = (idx == '0);
  assign is_last   = (idx == sdc_pkg::IDX_W'(sdc_pkg::NUM_MASSES - 1));

  // Head cell is the mass in work, its neighbour gives the right position
  assign x      = chain[0].pos;
  assign v      = chain[0].vel;
  assign x_r    = chain[1].pos;
  assign diff_l = (sdc_pkg::DW+1)'(x_l) - (sdc_pkg::DW+1)'(x);
  assign diff_r = (sdc_pkg::DW+1)'(x_r) - (sdc_pkg::DW+1)'(x);

  // Hand the updated mass, or the held one, back to the tail
  assign tail_in.pos = run ? x_new : x;
  assign tail_in.vel = run ? v_new : v;

  for (genvar j = 0; j < sdc_pkg::NUM_MASSES; j++) begin : g_cell
    if (j == sdc_pkg::NUM_MASSES - 1) begin : g_tail
      assign chain_in[j] = tail_in;
    end else begin : g_body
      assign chain_in[j] = chain[j+1];
    end
    sdc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (cell_load),
      .shift    (emit_fire),
      .init_pos (sdc_pkg::INIT_POS[j]),
      .din      (chain_in[j]),
      .dout     (chain[j])
    );
  end

  // Select multiplier operands for the step in hand
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_KQ: begin
        mul_a = sdc_pkg::OP_W'(stiffness) + sdc_pkg::OP_W'(sdc_pkg::KQ_BIAS);
        mul_b = sdc_pkg::RECIP_10;
      end
      S_M0: begin
        mul_a = sdc_pkg::OP_W'(stiffness);
        mul_b = sdc_pkg::OP_W'(x);
      end
      S_M1: begin
        mul_a = sdc_pkg::OP_W'(damping);
        mul_b = sdc_pkg::OP_W'(v);
      end
      S_M2: begin
        mul_a = sdc_pkg::OP_W'(kq);
        mul_b = sdc_pkg::OP_W'(diff_l);
      end
      S_M3: begin
        mul_a = sdc_pkg::OP_W'(kq);
        mul_b = sdc_pkg::OP_W'(diff_r);
      end
      S_M5: begin
        mul_a = sdc_pkg::OP_W'(acc);
        mul_b = sdc_pkg::OP_W'(time_step);
      end
      S_M7: begin
        mul_a = sdc_pkg::OP_W'(v_new);
        mul_b = sdc_pkg::OP_W'(time_step);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  sdc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign r         = sdc_pkg::rnd_frac(prod);
  assign force_fin = force_sum + (is_last ? '0 : sdc_pkg::ACC_W'(r));

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= sdc_pkg::STIFF_RST;
      damping     <= sdc_pkg::DAMP_RST;
      time_step   <= sdc_pkg::DT_RST;
      total_steps <= sdc_pkg::TOTAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sdc_pkg::REG_STIFFNESS:   stiffness   <= cfg_wdata;
        sdc_pkg::REG_DAMPING:     damping     <= cfg_wdata;
        sdc_pkg::REG_TIME_STEP:   time_step   <= cfg_wdata[sdc_pkg::DT_W-1:0];
        sdc_pkg::REG_TOTAL_STEPS: total_steps <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      steps <= '0;
      run   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            run <= run_next;
            if (restart) begin
              steps <= '0;
            end else if (run_next) begin
              steps <= steps + 1'b1;
            end
            state <= run_next ? S_KQ : S_EMIT;
          end
        end
        S_KQ:  state <= S_KQW;
        S_KQW: state <= S_M0;
        S_M0:  state <= S_M1;
        S_M1:  state <= S_M2;
        S_M2:  state <= S_M3;
        S_M3:  state <= S_M4;
        S_M4:  state <= S_M5;
        S_M5:  state <= S_M6;
        S_M6:  state <= S_M7;
        S_M7:  state <= S_M8;
        S_M8:  state <= S_EMIT;
        S_EMIT: begin
          if (emit_fire) begin
            if (is_last) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= run ? S_M0 : S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Compute the coupling constant, accumulate the force, update velocity and position and keep the left position
  always_ff @(posedge clk) begin
    case (state)
      S_KQW: kq <= prod[sdc_pkg::RECIP_SHIFT +: sdc_pkg::KQ_W];
      S_M1:  force_sum <= -sdc_pkg::ACC_W'(r);
      S_M2:  force_sum <= force_sum - sdc_pkg::ACC_W'(r);
      S_M3:  force_sum <= force_sum + (is_first ? '0 : sdc_pkg::ACC_W'(r));
      S_M4:  acc <= sdc_pkg::sat_word(force_fin);
      S_M6:  v_new <= sdc_pkg::sat_word(sdc_pkg::ACC_W'(v) + sdc_pkg::ACC_W'(r));
      S_M8:  x_new <= sdc_pkg::sat_word(sdc_pkg::ACC_W'(x) + sdc_pkg::ACC_W'(r));
      default: ;
    endcase
    if (emit_fire) begin
      x_l <= x;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      mass_index   <= sdc_pkg::MIDX_W'(idx);
      position     <= tail_in.pos;
      velocity     <= tail_in.vel;
      acceleration <= run ? acc : '0;
      step_count   <= steps;
      done_res     <= (steps >= total_steps);
      last         <= is_last;
    end
  end

`ifndef SYNTH
  // A new item only arrives with the mass counter back at the head
  a_idx_at_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (idx == '0))
    else $error("item accepted with a step still in progress");

  // Masses are handed off in index order
  a_idx_order: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && !is_last) |=> (idx == $past(idx) + 1'b1))
    else $error("mass index skipped or repeated");

  // The final hand-off returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && is_last) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after the final mass");

  // A held or reloaded chain reports no acceleration
  a_hold_acc: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && !run) |=> (acceleration == '0))
    else $error("acceleration reported on a hold or restart");
`endif

endmodule

`default_nettype wire

// ----- rtl/sdc_cell.sv -----
`default_nettype none

module sdc_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic                          shift,
  input  wire logic signed [sdc_pkg::DW-1:0] init_pos,
  input  wire sdc_pkg::mass_t                din,
  output sdc_pkg::mass_t                     dout
);

  // Reload the initial perturbation, or take the neighbour's state on a shift
  always_ff @(posedge clk) begin
    if (rst || load) begin
      dout.pos <= init_pos;
      dout.vel <= '0;
    end else if (shift) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sdc_mul.sv -----
`default_nettype none

module sdc_mul (
  input  wire logic                              clk,
  input  wire logic signed [sdc_pkg::OP_W-1:0]   a,
  input  wire logic signed [sdc_pkg::OP_W-1:0]   b,
  output logic signed [sdc_pkg::PROD_W-1:0]      p
);

  // Register the full product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire
